// ===== rtl/core/rta_pkg.sv =====
package rta_pkg;

    localparam int FLAG_W = 16;
    localparam int DATA_W = 32;
    localparam int IDX_W  = 3;
    localparam int CFG_W  = 4;

    localparam logic REG_REGION_COUNT   = 1'b0;
    localparam logic REG_CACHE_FLAG_BIT = 1'b1;

    typedef enum logic [1:0] {
        OP_LOAD  = 2'd0,
        OP_ALLOC = 2'd1,
        OP_FREE  = 2'd2,
        OP_PUSH  = 2'd3
    } opcode_t;

    typedef enum logic [2:0] {
        STAT_OK       = 3'd0,
        STAT_NONE     = 3'd1,
        STAT_OVERFLOW = 3'd2,
        STAT_CACHE    = 3'd3,
        STAT_BADIDX   = 3'd4
    } status_t;

    typedef enum logic [1:0] {
        FSM_IDLE  = 2'd0,
        FSM_ISSUE = 2'd1,
        FSM_CHECK = 2'd2,
        FSM_RESP  = 2'd3
    } fsm_state_t;

    typedef struct packed {
        logic [CFG_W-1:0] region_count;
        logic [CFG_W-1:0] cache_flag_bit;
    } cfg_t;

    typedef struct packed {
        logic [FLAG_W-1:0] flags;
        logic [DATA_W-1:0] size;
        logic [DATA_W-1:0] base;
    } tbl_entry_t;

    typedef struct packed {
        logic              busy;
        logic [DATA_W-1:0] fill;
    } entry_state_t;

endpackage

// ===== rtl/core/rta_cfg_regs.sv =====
module rta_cfg_regs (
    input  logic          aclk,
    input  logic          aresetn,
    input  logic          psel,
    input  logic          penable,
    input  logic          pwrite,
    input  logic [2:0]    paddr,
    input  logic [31:0]   pwdata,
    output logic [31:0]   prdata,
    output logic          pready,
    output rta_pkg::cfg_t cfg
);
    import rta_pkg::*;

    logic [CFG_W-1:0] region_count_reg, region_count_next;
    logic [CFG_W-1:0] cache_flag_bit_reg, cache_flag_bit_next;
    logic             wr_en;

    assign pready = 1'b1;
    assign wr_en  = psel & penable & pwrite & pready;

    always_comb begin
        region_count_next   = region_count_reg;
        cache_flag_bit_next = cache_flag_bit_reg;
        if (wr_en) begin
            case (paddr[2])
                REG_REGION_COUNT:   region_count_next   = pwdata[CFG_W-1:0];
                REG_CACHE_FLAG_BIT: cache_flag_bit_next = pwdata[CFG_W-1:0];
                default: ;
            endcase
        end
    end

    always_comb begin
        case (paddr[2])
            REG_REGION_COUNT:   prdata = {{(32-CFG_W){1'b0}}, region_count_reg};
            REG_CACHE_FLAG_BIT: prdata = {{(32-CFG_W){1'b0}}, cache_flag_bit_reg};
            default:            prdata = '0;
        endcase
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            region_count_reg   <= '0;
            cache_flag_bit_reg <= '0;
        end else begin
            region_count_reg   <= region_count_next;
            cache_flag_bit_reg <= cache_flag_bit_next;
        end
    end

    assign cfg.region_count   = region_count_reg;
    assign cfg.cache_flag_bit = cache_flag_bit_reg;

endmodule

// ===== rtl/core/rta_table_mem.sv =====
module rta_table_mem #(
    parameter int MAX_REGIONS = 8,
    parameter int AW          = 3
) (
    input  logic                aclk,
    input  logic                we,
    input  logic [AW-1:0]       waddr,
    input  rta_pkg::tbl_entry_t wdata,
    input  logic                re,
    input  logic [AW-1:0]       raddr,
    output rta_pkg::tbl_entry_t rdata
);
    import rta_pkg::*;

    tbl_entry_t mem [MAX_REGIONS];
    tbl_entry_t rdata_reg;

    always_ff @(posedge aclk) begin
        if (we) begin
            mem[waddr] <= wdata;
        end
        if (re) begin
            rdata_reg <= mem[raddr];
        end
    end

    assign rdata = rdata_reg;

endmodule

// ===== rtl/core/rta_state_mem.sv =====
module rta_state_mem #(
    parameter int MAX_REGIONS = 8,
    parameter int AW          = 3
) (
    input  logic                  aclk,
    input  logic                  aresetn,
    input  logic                  we,
    input  logic [AW-1:0]         waddr,
    input  rta_pkg::entry_state_t wdata,
    input  logic                  re,
    input  logic [AW-1:0]         raddr,
    output rta_pkg::entry_state_t rdata
);
    import rta_pkg::*;

    entry_state_t           mem [MAX_REGIONS];
    entry_state_t           rdata_reg;
    logic [MAX_REGIONS-1:0] vld_reg;
    logic                   rd_vld_reg;

    always_ff @(posedge aclk) begin
        if (we) begin
            mem[waddr] <= wdata;
        end
        if (re) begin
            rdata_reg <= mem[raddr];
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            vld_reg    <= '0;
            rd_vld_reg <= 1'b0;
        end else begin
            if (we) begin
                vld_reg[waddr] <= 1'b1;
            end
            if (re) begin
                rd_vld_reg <= vld_reg[raddr];
            end
        end
    end

    assign rdata = rd_vld_reg ? rdata_reg : '0;

endmodule

// ===== rtl/core/region_table_allocator.sv =====
// Channel   Direction  Handshake          Payload
// s_        in         s_tvalid/s_tready  operation and its operands
// m_        out        m_tvalid/m_tready  status, granted entry, address
// apb       in         psel/penable       region_count at 0x0, cache_flag_bit at 0x4
//
// Load, free and bad index pass from acceptance through ISSUE and RESP to the output register.
// Push adds a CHECK state after ISSUE. Allocate scans entries in CHECK, one after another, up to
// min(region_count, MAX_REGIONS); the single read port of the entry tables sets the pace.
// One operation at a time; the next is taken once the previous result is registered.
// Reset is synchronous on aresetn low and clears fill and busy marks at once.
// A stalled m_ side holds the block in its response state.
module region_table_allocator #(
    parameter int MAX_REGIONS = 8
) (
    input  logic        aclk,
    input  logic        aresetn,
    input  logic        s_tvalid,
    output logic        s_tready,
    // [2:0] region_index, [18:3] request_flags, [50:19] request_size, [82:51] region_base
    input  logic [87:0] s_tdata,
    // [1:0] opcode
    input  logic [1:0]  s_tuser,
    output logic        m_tvalid,
    input  logic        m_tready,
    // [2:0] status, [5:3] granted_index, [37:6] address
    output logic [39:0] m_tdata,
    input  logic        psel,
    input  logic        penable,
    input  logic        pwrite,
    input  logic [2:0]  paddr,
    input  logic [31:0] pwdata,
    output logic [31:0] prdata,
    output logic        pready
);
    import rta_pkg::*;

    localparam int AW = (MAX_REGIONS > 1) ? $clog2(MAX_REGIONS) : 1;
    localparam int CW = $clog2(MAX_REGIONS + 1);
    localparam logic [6:0] MAX_N = 7'(MAX_REGIONS);

    cfg_t         cfg;
    fsm_state_t   state_reg, state_next;
    opcode_t      op_reg, op_next;
    logic [IDX_W-1:0]  idx_reg, idx_next;
    logic [FLAG_W-1:0] flags_reg, flags_next;
    logic [DATA_W-1:0] size_reg, size_next;
    logic [DATA_W-1:0] base_reg, base_next;
    logic [CW-1:0]     scan_reg, scan_next;
    status_t           res_status_reg, res_status_next;
    logic [IDX_W-1:0]  res_grant_reg, res_grant_next;
    logic [DATA_W-1:0] res_addr_reg, res_addr_next;
    logic              m_valid_reg, m_valid_next;
    logic [39:0]       m_data_reg, m_data_next;

    logic [6:0]    lim_wide;
    logic [CW-1:0] lim;
    logic [CW-1:0] scan_inc;
    logic          idx_ok;
    logic [AW-1:0] idx_addr;
    logic          s_accept;

    logic         tbl_we, tbl_re, st_we, st_re;
    logic [AW-1:0] tbl_waddr, st_waddr, rd_addr;
    tbl_entry_t   tbl_wdata, tbl_rdata;
    entry_state_t st_wdata, st_rdata;

    logic              alloc_match;
    logic [DATA_W-1:0] room, push_addr, push_fill;
    logic              push_over;

    rta_cfg_regs u_cfg (
        .aclk    (aclk),
        .aresetn (aresetn),
        .psel    (psel),
        .penable (penable),
        .pwrite  (pwrite),
        .paddr   (paddr),
        .pwdata  (pwdata),
        .prdata  (prdata),
        .pready  (pready),
        .cfg     (cfg)
    );

    rta_table_mem #(.MAX_REGIONS(MAX_REGIONS), .AW(AW)) u_tbl (
        .aclk  (aclk),
        .we    (tbl_we),
        .waddr (tbl_waddr),
        .wdata (tbl_wdata),
        .re    (tbl_re),
        .raddr (rd_addr),
        .rdata (tbl_rdata)
    );

    rta_state_mem #(.MAX_REGIONS(MAX_REGIONS), .AW(AW)) u_st (
        .aclk    (aclk),
        .aresetn (aresetn),
        .we      (st_we),
        .waddr   (st_waddr),
        .wdata   (st_wdata),
        .re      (st_re),
        .raddr   (rd_addr),
        .rdata   (st_rdata)
    );

    assign lim_wide = ({3'b000, cfg.region_count} > MAX_N) ? MAX_N : {3'b000, cfg.region_count};
    assign lim      = lim_wide[CW-1:0];
    assign scan_inc = scan_reg + CW'(1);
    assign idx_ok   = ({4'b0000, idx_reg} < MAX_N);
    assign idx_addr = AW'(idx_reg);
    assign s_accept = s_tvalid & s_tready;

    assign alloc_match = (tbl_rdata.flags == flags_reg)
                       && (flags_reg[cfg.cache_flag_bit] || (size_reg <= tbl_rdata.size))
                       && !st_rdata.busy;

    assign room      = tbl_rdata.size - st_rdata.fill;
    assign push_over = (st_rdata.fill > tbl_rdata.size) || (size_reg > room);
    assign push_addr = tbl_rdata.base + st_rdata.fill;
    assign push_fill = st_rdata.fill + size_reg;

    always_comb begin
        state_next      = state_reg;
        op_next         = op_reg;
        idx_next        = idx_reg;
        flags_next      = flags_reg;
        size_next       = size_reg;
        base_next       = base_reg;
        scan_next       = scan_reg;
        res_status_next = res_status_reg;
        res_grant_next  = res_grant_reg;
        res_addr_next   = res_addr_reg;
        m_valid_next    = m_valid_reg;
        m_data_next     = m_data_reg;
        s_tready        = 1'b0;
        tbl_we          = 1'b0;
        tbl_waddr       = idx_addr;
        tbl_wdata       = '{flags: flags_reg, size: size_reg, base: base_reg};
        tbl_re          = 1'b0;
        st_we           = 1'b0;
        st_waddr        = idx_addr;
        st_wdata        = '{busy: 1'b0, fill: '0};
        st_re           = 1'b0;
        rd_addr         = (op_reg == OP_ALLOC) ? scan_reg[AW-1:0] : idx_addr;

        if (m_valid_reg && m_tready) begin
            m_valid_next = 1'b0;
        end

        case (state_reg)
            FSM_IDLE: begin
                s_tready = 1'b1;
                if (s_accept) begin
                    op_next    = opcode_t'(s_tuser);
                    idx_next   = s_tdata[2:0];
                    flags_next = s_tdata[18:3];
                    size_next  = s_tdata[50:19];
                    base_next  = s_tdata[82:51];
                    scan_next  = '0;
                    state_next = FSM_ISSUE;
                end
            end
            FSM_ISSUE: begin
                res_status_next = STAT_OK;
                res_grant_next  = '0;
                res_addr_next   = '0;
                if (op_reg == OP_ALLOC) begin
                    if (lim == '0) begin
                        res_status_next = STAT_NONE;
                        state_next      = FSM_RESP;
                    end else begin
                        tbl_re     = 1'b1;
                        st_re      = 1'b1;
                        state_next = FSM_CHECK;
                    end
                end else if (!idx_ok) begin
                    res_status_next = STAT_BADIDX;
                    state_next      = FSM_RESP;
                end else begin
                    case (op_reg)
                        OP_LOAD: begin
                            tbl_we     = 1'b1;
                            state_next = FSM_RESP;
                        end
                        OP_FREE: begin
                            st_we      = 1'b1;
                            state_next = FSM_RESP;
                        end
                        OP_PUSH: begin
                            tbl_re     = 1'b1;
                            st_re      = 1'b1;
                            state_next = FSM_CHECK;
                        end
                        default: state_next = FSM_RESP;
                    endcase
                end
            end
            FSM_CHECK: begin
                if (op_reg == OP_ALLOC) begin
                    if (alloc_match) begin
                        st_we           = 1'b1;
                        st_waddr        = scan_reg[AW-1:0];
                        st_wdata        = '{busy: 1'b1, fill: st_rdata.fill};
                        res_grant_next  = IDX_W'(scan_reg);
                        state_next      = FSM_RESP;
                    end else if (scan_inc >= lim) begin
                        res_status_next = STAT_NONE;
                        state_next      = FSM_RESP;
                    end else begin
                        scan_next = scan_inc;
                        rd_addr   = scan_inc[AW-1:0];
                        tbl_re    = 1'b1;
                        st_re     = 1'b1;
                    end
                end else begin
                    if (tbl_rdata.flags[cfg.cache_flag_bit]) begin
                        res_status_next = STAT_CACHE;
                    end else if (push_over) begin
                        res_status_next = STAT_OVERFLOW;
                    end else begin
                        st_we         = 1'b1;
                        st_wdata      = '{busy: st_rdata.busy, fill: push_fill};
                        res_addr_next = push_addr;
                    end
                    state_next = FSM_RESP;
                end
            end
            FSM_RESP: begin
                if (!m_valid_reg || m_tready) begin
                    m_valid_next = 1'b1;
                    m_data_next  = {2'b00, res_addr_reg, res_grant_reg, res_status_reg};
                    state_next   = FSM_IDLE;
                end
            end
            default: state_next = FSM_IDLE;
        endcase
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg   <= FSM_IDLE;
            scan_reg    <= '0;
            m_valid_reg <= 1'b0;
        end else begin
            state_reg   <= state_next;
            scan_reg    <= scan_next;
            m_valid_reg <= m_valid_next;
        end
    end

    always_ff @(posedge aclk) begin
        op_reg         <= op_next;
        idx_reg        <= idx_next;
        flags_reg      <= flags_next;
        size_reg       <= size_next;
        base_reg       <= base_next;
        res_status_reg <= res_status_next;
        res_grant_reg  <= res_grant_next;
        res_addr_reg   <= res_addr_next;
        m_data_reg     <= m_data_next;
    end

    assign m_tvalid = m_valid_reg;
    assign m_tdata  = m_data_reg;

`ifndef SYNTHESIS
    a_scan_in_range: assert property (@(posedge aclk) disable iff (!aresetn)
        (state_reg == FSM_CHECK && op_reg == OP_ALLOC) |-> (scan_reg < lim))
        else $error("allocation scan beyond searched entries");

    a_accept_to_issue: assert property (@(posedge aclk) disable iff (!aresetn)
        s_accept |=> (state_reg == FSM_ISSUE))
        else $error("accepted transaction not issued");

    a_result_from_resp: assert property (@(posedge aclk) disable iff (!aresetn)
        (m_valid_next && !m_valid_reg) |-> (state_reg == FSM_RESP))
        else $error("result loaded outside response state");

    a_status_legal: assert property (@(posedge aclk) disable iff (!aresetn)
        m_valid_reg |-> (m_data_reg[2:0] <= STAT_BADIDX))
        else $error("illegal status code");
`endif

endmodule

// ===== test/region_table_allocator_checker.sv =====
`timescale 1ns / 1ps

module region_table_allocator_checker #(
    parameter int MAX_REGIONS = 8
) (
    input  logic        aclk,
    input  logic        aresetn,
    input  logic        s_tvalid,
    input  logic        s_tready,
    // [2:0] region_index, [18:3] request_flags, [50:19] request_size, [82:51] region_base
    input  logic [87:0] s_tdata,
    // [1:0] opcode
    input  logic [1:0]  s_tuser,
    input  logic        m_tvalid,
    input  logic        m_tready,
    // [2:0] status, [5:3] granted_index, [37:6] address
    input  logic [39:0] m_tdata,
    input  logic        psel,
    input  logic        penable,
    input  logic        pwrite,
    input  logic [2:0]  paddr,
    input  logic [31:0] pwdata,
    input  logic        pready,
    output int          errors,
    output int          outstanding
);
    import rta_pkg::*;

    localparam logic [2:0] ADDR_REGION_COUNT   = {REG_REGION_COUNT, 2'b00};
    localparam logic [2:0] ADDR_CACHE_FLAG_BIT = {REG_CACHE_FLAG_BIT, 2'b00};

    typedef struct packed {
        status_t           status;
        logic [IDX_W-1:0]  granted;
        logic [DATA_W-1:0] address;
    } outcome_t;

    logic [FLAG_W-1:0] tbl_flags [MAX_REGIONS];
    logic [DATA_W-1:0] tbl_size  [MAX_REGIONS];
    logic [DATA_W-1:0] tbl_base  [MAX_REGIONS];
    logic [DATA_W-1:0] tbl_fill  [MAX_REGIONS];
    logic              tbl_busy  [MAX_REGIONS];
    logic [CFG_W-1:0]  region_count;
    logic [CFG_W-1:0]  cache_bit;
    outcome_t          awaited_results [$];
    outcome_t          oldest;

    function automatic outcome_t table_outcome(
        input opcode_t           op,
        input logic [IDX_W-1:0]  idx,
        input logic [FLAG_W-1:0] flags,
        input logic [DATA_W-1:0] size,
        input logic [DATA_W-1:0] base
    );
        outcome_t          res;
        int                limit;
        logic [DATA_W-1:0] cap;
        logic [DATA_W-1:0] fill;
        res = '{status: STAT_OK, granted: '0, address: '0};
        if (op == OP_ALLOC) begin
            res.status = STAT_NONE;
            limit = (int'(region_count) < MAX_REGIONS) ? int'(region_count) : MAX_REGIONS;
            for (int i = 0; i < limit; i++) begin
                if (res.status == STAT_NONE && tbl_flags[i] == flags &&
                    (flags[cache_bit] || size <= tbl_size[i]) && !tbl_busy[i]) begin
                    tbl_busy[i] = 1'b1;
                    res.status  = STAT_OK;
                    res.granted = IDX_W'(i);
                end
            end
        end else if (int'(idx) >= MAX_REGIONS) begin
            res.status = STAT_BADIDX;
        end else if (op == OP_LOAD) begin
            tbl_flags[idx] = flags;
            tbl_size[idx]  = size;
            tbl_base[idx]  = base;
        end else if (op == OP_FREE) begin
            tbl_fill[idx] = '0;
            tbl_busy[idx] = 1'b0;
        end else begin
            cap  = tbl_size[idx];
            fill = tbl_fill[idx];
            if (tbl_flags[idx][cache_bit]) begin
                res.status = STAT_CACHE;
            end else if (fill > cap || size > cap - fill) begin
                res.status = STAT_OVERFLOW;
            end else begin
                res.address   = tbl_base[idx] + fill;
                tbl_fill[idx] = fill + size;
            end
        end
        return res;
    endfunction

    always @(posedge aclk) begin
        if (!aresetn) begin
            for (int i = 0; i < MAX_REGIONS; i++) begin
                tbl_flags[i] = '0;
                tbl_size[i]  = '0;
                tbl_base[i]  = '0;
                tbl_fill[i]  = '0;
                tbl_busy[i]  = 1'b0;
            end
            region_count = '0;
            cache_bit    = '0;
            awaited_results.delete();
        end else begin
            if (psel && penable && pwrite && pready) begin
                if (paddr == ADDR_REGION_COUNT) begin
                    region_count = pwdata[CFG_W-1:0];
                end else if (paddr == ADDR_CACHE_FLAG_BIT) begin
                    cache_bit = pwdata[CFG_W-1:0];
                end
            end
            if (m_tvalid && m_tready) begin
                if (awaited_results.size() == 0) begin
                    errors++;
                    $error("result transaction with nothing awaited: %h", m_tdata);
                end else begin
                    oldest = awaited_results.pop_front();
                    if (m_tdata[2:0] !== oldest.status) begin
                        errors++;
                        $error("status: expected %0d, got %0d", oldest.status, m_tdata[2:0]);
                    end
                    if (m_tdata[5:3] !== oldest.granted) begin
                        errors++;
                        $error("granted_index: expected %0d, got %0d",
                               oldest.granted, m_tdata[5:3]);
                    end
                    if (m_tdata[37:6] !== oldest.address) begin
                        errors++;
                        $error("address: expected %h, got %h", oldest.address, m_tdata[37:6]);
                    end
                end
            end
            if (s_tvalid && s_tready) begin
                awaited_results.push_back(table_outcome(opcode_t'(s_tuser), s_tdata[2:0],
                    s_tdata[18:3], s_tdata[50:19], s_tdata[82:51]));
            end
        end
        outstanding = awaited_results.size();
    end

endmodule

// ===== test/region_table_allocator_tb.sv =====
`timescale 1ns / 1ps

module region_table_allocator_tb;
    import rta_pkg::*;

    localparam int PHASES          = 8;
    localparam int ITEMS_PER_PHASE = 250;
    localparam int TAIL_CYCLES     = 20;
    localparam int TIMEOUT_NS      = 7_200_000;

    localparam logic [2:0] ADDR_REGION_COUNT   = {REG_REGION_COUNT, 2'b00};
    localparam logic [2:0] ADDR_CACHE_FLAG_BIT = {REG_CACHE_FLAG_BIT, 2'b00};

    logic        aclk;
    logic        aresetn;
    logic        s_tvalid;
    logic        s_tready;
    logic [87:0] s_tdata;
    logic [1:0]  s_tuser;
    logic        m_tvalid;
    logic        m_tready;
    logic [39:0] m_tdata;
    logic        psel;
    logic        penable;
    logic        pwrite;
    logic [2:0]  paddr;
    logic [31:0] pwdata;
    logic [31:0] prdata;
    logic        pready;
    int          errors;
    int          outstanding;

    int          src_idle_pct;
    int          sink_stall_pct;
    logic [15:0] loaded_flags [8];
    logic [31:0] loaded_size  [8];
    logic [15:0] flag_pool    [4];

    region_table_allocator #(
        .MAX_REGIONS(8)
    ) u_dut (
        .aclk    (aclk),
        .aresetn (aresetn),
        .s_tvalid(s_tvalid),
        .s_tready(s_tready),
        .s_tdata (s_tdata),
        .s_tuser (s_tuser),
        .m_tvalid(m_tvalid),
        .m_tready(m_tready),
        .m_tdata (m_tdata),
        .psel    (psel),
        .penable (penable),
        .pwrite  (pwrite),
        .paddr   (paddr),
        .pwdata  (pwdata),
        .prdata  (prdata),
        .pready  (pready)
    );

    region_table_allocator_checker #(
        .MAX_REGIONS(8)
    ) u_checker (
        .aclk       (aclk),
        .aresetn    (aresetn),
        .s_tvalid   (s_tvalid),
        .s_tready   (s_tready),
        .s_tdata    (s_tdata),
        .s_tuser    (s_tuser),
        .m_tvalid   (m_tvalid),
        .m_tready   (m_tready),
        .m_tdata    (m_tdata),
        .psel       (psel),
        .penable    (penable),
        .pwrite     (pwrite),
        .paddr      (paddr),
        .pwdata     (pwdata),
        .pready     (pready),
        .errors     (errors),
        .outstanding(outstanding)
    );

    initial aclk = 1'b0;
    always #6 aclk = ~aclk;

    always @(negedge aclk) begin
        m_tready <= (sink_stall_pct == 0) || ($urandom_range(1, 100) > sink_stall_pct);
    end

    task automatic write_register(input logic [2:0] addr, input logic [31:0] value);
        psel    <= 1'b1;
        penable <= 1'b0;
        pwrite  <= 1'b1;
        paddr   <= addr;
        pwdata  <= value;
        @(negedge aclk);
        penable <= 1'b1;
        @(posedge aclk);
        while (!pready) @(posedge aclk);
        @(negedge aclk);
        psel    <= 1'b0;
        penable <= 1'b0;
        pwrite  <= 1'b0;
        @(negedge aclk);
    endtask

    task automatic drain_results();
        do @(negedge aclk); while (outstanding != 0);
    endtask

    task automatic issue_op(
        input opcode_t     op,
        input logic [2:0]  idx,
        input logic [15:0] flags,
        input logic [31:0] size,
        input logic [31:0] base
    );
        while (src_idle_pct != 0 && $urandom_range(1, 100) <= src_idle_pct) begin
            s_tvalid <= 1'b0;
            @(negedge aclk);
        end
        if (op == OP_LOAD) begin
            loaded_flags[idx] = flags;
            loaded_size[idx]  = size;
        end
        s_tvalid <= 1'b1;
        s_tuser  <= op;
        s_tdata  <= {5'b0, base, size, flags, idx};
        @(posedge aclk);
        while (!s_tready) @(posedge aclk);
        @(negedge aclk);
    endtask

    task automatic random_transaction();
        int          pick;
        int          e;
        opcode_t     op;
        logic [2:0]  idx;
        logic [15:0] flags;
        logic [31:0] size;
        logic [31:0] base;
        pick  = $urandom_range(0, 99);
        e     = $urandom_range(0, 7);
        idx   = 3'($urandom_range(0, 7));
        flags = 16'($urandom);
        size  = $urandom;
        base  = $urandom;
        if (pick < 15) begin
            op = OP_LOAD;
            if ($urandom_range(0, 4) != 0) flags = flag_pool[$urandom_range(0, 3)];
            case ($urandom_range(0, 9))
                0:       size = '0;
                1:       size = '1;
                2, 3:    size = $urandom;
                default: size = $urandom_range(0, 2048);
            endcase
            if ($urandom_range(0, 3) == 0) base = 32'hFFFF_FFFF - $urandom_range(0, 2048);
        end else if (pick < 45) begin
            op = OP_ALLOC;
            if ($urandom_range(0, 4) != 0) flags = loaded_flags[e];
            if ($urandom_range(0, 9) < 7) size = $urandom_range(0, loaded_size[e]);
        end else if (pick < 65) begin
            op = OP_FREE;
        end else begin
            op = OP_PUSH;
            case ($urandom_range(0, 9))
                0:       size = '0;
                1:       size = $urandom;
                2, 3:    size = $urandom_range(0, loaded_size[idx]);
                default: size = $urandom_range(0, 64);
            endcase
        end
        issue_op(op, idx, flags, size, base);
    endtask

    initial begin
        #(TIMEOUT_NS);
        $display("Test completed with failures");
        $finish;
    end

    initial begin
        int rc_plan [PHASES];
        int cb_plan [PHASES];
        rc_plan = '{8, 15, 0, 3, 8, 1, 7, 5};
        cb_plan = '{0, 15, 5, 0, 15, 9, 3, 12};
        aresetn        = 1'b0;
        s_tvalid       = 1'b0;
        s_tdata        = '0;
        s_tuser        = OP_LOAD;
        psel           = 1'b0;
        penable        = 1'b0;
        pwrite         = 1'b0;
        paddr          = '0;
        pwdata         = '0;
        src_idle_pct   = 0;
        sink_stall_pct = 0;
        for (int i = 0; i < 8; i++) begin
            loaded_flags[i] = '0;
            loaded_size[i]  = '0;
        end
        for (int i = 0; i < 4; i++) flag_pool[i] = 16'($urandom);
        repeat (11) @(posedge aclk);
        @(negedge aclk);
        aresetn <= 1'b1;
        @(negedge aclk);

        write_register(ADDR_REGION_COUNT, 32'd8);
        write_register(ADDR_CACHE_FLAG_BIT, 32'd0);

        // load every entry before anything reads the table
        issue_op(OP_LOAD, 3'd0, 16'h0000, 32'd0, 32'd0);
        issue_op(OP_LOAD, 3'd1, 16'hFFFF, 32'hFFFF_FFFF, 32'hFFFF_FFFF);
        issue_op(OP_LOAD, 3'd2, 16'h1234, 32'd100, 32'hFFFF_FFF0);
        issue_op(OP_LOAD, 3'd3, 16'h1234, 32'd200, 32'h0000_1000);
        issue_op(OP_LOAD, 3'd4, 16'h0001, 32'd64, 32'h0000_2000);
        issue_op(OP_LOAD, 3'd5, 16'h8000, 32'd16, 32'h8000_0000);
        issue_op(OP_LOAD, 3'd6, 16'h5555, 32'd50, 32'h0000_3000);
        issue_op(OP_LOAD, 3'd7, 16'hAAAA, 32'd8, 32'h7FFF_FFFF);
        issue_op(OP_ALLOC, 3'd0, 16'h1234, 32'd150, 32'd0);
        issue_op(OP_ALLOC, 3'd0, 16'h1234, 32'd50, 32'd0);
        issue_op(OP_ALLOC, 3'd0, 16'h1234, 32'd0, 32'd0);
        issue_op(OP_ALLOC, 3'd0, 16'h0001, 32'hFFFF_FFFF, 32'd0);
        issue_op(OP_PUSH, 3'd2, 16'h0000, 32'd16, 32'd0);
        issue_op(OP_PUSH, 3'd2, 16'h0000, 32'd84, 32'd0);
        issue_op(OP_PUSH, 3'd2, 16'h0000, 32'd0, 32'd0);
        issue_op(OP_PUSH, 3'd2, 16'h0000, 32'd1, 32'd0);
        issue_op(OP_PUSH, 3'd4, 16'h0000, 32'd1, 32'd0);
        issue_op(OP_PUSH, 3'd7, 16'h0000, 32'd9, 32'd0);
        issue_op(OP_LOAD, 3'd2, 16'h1234, 32'd50, 32'hFFFF_FFF0);
        issue_op(OP_PUSH, 3'd2, 16'h0000, 32'd0, 32'd0);
        issue_op(OP_FREE, 3'd2, 16'h0000, 32'd0, 32'd0);
        issue_op(OP_FREE, 3'd0, 16'h0000, 32'd0, 32'd0);
        issue_op(OP_PUSH, 3'd0, 16'h0000, 32'd0, 32'd0);
        issue_op(OP_PUSH, 3'd5, 16'h0000, 32'd16, 32'd0);
        issue_op(OP_PUSH, 3'd3, 16'h0000, 32'hFFFF_FFFF, 32'd0);

        for (int phase = 0; phase < PHASES; phase++) begin
            s_tvalid <= 1'b0;
            drain_results();
            write_register(ADDR_REGION_COUNT, 32'(rc_plan[phase]));
            write_register(ADDR_CACHE_FLAG_BIT, 32'(cb_plan[phase]));
            src_idle_pct   = (phase % 4 == 1) ? 82 : (phase % 4 == 3) ? 29 : 0;
            sink_stall_pct = (phase % 4 == 2) ? 82 : (phase % 4 == 3) ? 29 : 0;
            for (int k = 0; k < ITEMS_PER_PHASE; k++) begin
                if (k == ITEMS_PER_PHASE / 2) begin
                    s_tvalid <= 1'b0;
                    drain_results();
                end
                random_transaction();
            end
        end

        s_tvalid <= 1'b0;
        drain_results();
        repeat (TAIL_CYCLES) @(negedge aclk);
        if (errors == 0 && outstanding == 0) begin
            $display("Test completed successfully");
        end else begin
            $display("Test completed with failures");
        end
        $finish;
    end

endmodule
